/* hdl/ghs_pkg.sv */
// package for the gzip header stripper: codes, phases and word types
package ghs_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SkipW   = 16;
  localparam int unsigned FlagsW  = 4;
  localparam int unsigned CrcCntW = 2;

  localparam logic [ByteW-1:0] Magic1       = 8'h1f;
  localparam logic [ByteW-1:0] Magic2       = 8'h8b;
  localparam logic [ByteW-1:0] MethodDefl   = 8'h08;
  localparam logic [ByteW-1:0] FlagRsvdMask = 8'he0;
  localparam logic [SkipW-1:0] FixedSkip    = 16'd6;

  // flag byte bits 1..4 shifted down by one
  localparam logic [FlagsW-1:0] HfHcrc    = 4'h1;
  localparam logic [FlagsW-1:0] HfExtra   = 4'h2;
  localparam logic [FlagsW-1:0] HfName    = 4'h4;
  localparam logic [FlagsW-1:0] HfComment = 4'h8;

  typedef enum logic [3:0] {
    PH_MAGIC1,
    PH_MAGIC2,
    PH_METHOD,
    PH_FLAGS,
    PH_SKIP6,
    PH_XLEN_LO,
    PH_XLEN_HI,
    PH_XDATA,
    PH_NAME,
    PH_COMMENT,
    PH_HCRC,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_HEADER,
    ST_OK,
    ST_BAD_MAGIC,
    ST_BAD_METHOD,
    ST_TRUNCATED,
    ST_EMPTY
  } status_t;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_input;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    status_t          status;
  } result_t;

endpackage

/* hdl/ghs_in_reg.sv */
// input word register with valid flag
module ghs_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ghs_pkg::item_t in_item,
  input  logic          take,      // downstream consumes the held word
  output logic          held_valid,
  output ghs_pkg::item_t held_item
);
  import ghs_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

/* hdl/ghs_parser.sv */
// header parse state machine: state registers and per-word next-state logic
module ghs_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,     // one word is processed this cycle
  input  ghs_pkg::item_t   item,
  output ghs_pkg::result_t result
);
  import ghs_pkg::*;

  typedef struct packed {
    phase_t phase;
    logic   set_ok;
    logic   clr_crc;
  } sect_t;

  phase_t             phase_r, phase_nxt;
  logic [SkipW-1:0]   skip_r, skip_nxt;
  logic [ByteW-1:0]   xlen_lo_r, xlen_lo_nxt;
  logic [FlagsW-1:0]  flags_r, flags_nxt;
  status_t            status_r, status_nxt;
  logic [CrcCntW-1:0] crc_cnt_r, crc_cnt_nxt;

  logic [SkipW-1:0]   skip_dec;
  logic [SkipW-1:0]   xlen_full;
  logic [CrcCntW-1:0] crc_inc;
  logic               pay_valid;
  sect_t              sect;

  // first present optional section at or after the given phase
  function automatic sect_t enter_section(input phase_t from, input logic [FlagsW-1:0] fl);
    sect_t s;
    s = '{phase: PH_PAYLOAD, set_ok: 1'b1, clr_crc: 1'b0};
    if (from <= PH_XLEN_LO && (fl & HfExtra) != '0) begin
      s = '{phase: PH_XLEN_LO, set_ok: 1'b0, clr_crc: 1'b0};
    end else if (from <= PH_NAME && (fl & HfName) != '0) begin
      s = '{phase: PH_NAME, set_ok: 1'b0, clr_crc: 1'b0};
    end else if (from <= PH_COMMENT && (fl & HfComment) != '0) begin
      s = '{phase: PH_COMMENT, set_ok: 1'b0, clr_crc: 1'b0};
    end else if (from <= PH_HCRC && (fl & HfHcrc) != '0) begin
      s = '{phase: PH_HCRC, set_ok: 1'b0, clr_crc: 1'b1};
    end
    return s;
  endfunction

  assign skip_dec  = skip_r - SkipW'(1);
  assign xlen_full = {item.in_byte, xlen_lo_r};
  assign crc_inc   = crc_cnt_r + CrcCntW'(1);

  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    xlen_lo_nxt = xlen_lo_r;
    flags_nxt   = flags_r;
    status_nxt  = status_r;
    crc_cnt_nxt = crc_cnt_r;
    pay_valid   = 1'b0;
    sect        = '{phase: PH_PAYLOAD, set_ok: 1'b0, clr_crc: 1'b0};

    if (phase_r == PH_STOPPED) begin
      // stopped: words are ignored until reset
    end else if (item.end_of_input) begin
      phase_nxt = PH_STOPPED;
      if (phase_r == PH_MAGIC1) begin
        status_nxt = ST_EMPTY;
      end else if (phase_r == PH_PAYLOAD) begin
        status_nxt = ST_OK;
      end else begin
        status_nxt = ST_TRUNCATED;
      end
    end else begin
      case (phase_r)
        PH_MAGIC1: begin
          if (item.in_byte == Magic1) begin
            phase_nxt = PH_MAGIC2;
          end else begin
            phase_nxt  = PH_STOPPED;
            status_nxt = ST_BAD_MAGIC;
          end
        end
        PH_MAGIC2: begin
          if (item.in_byte == Magic2) begin
            phase_nxt = PH_METHOD;
          end else begin
            phase_nxt  = PH_STOPPED;
            status_nxt = ST_BAD_MAGIC;
          end
        end
        PH_METHOD: begin
          if (item.in_byte == MethodDefl) begin
            phase_nxt = PH_FLAGS;
          end else begin
            phase_nxt  = PH_STOPPED;
            status_nxt = ST_BAD_METHOD;
          end
        end
        PH_FLAGS: begin
          if ((item.in_byte & FlagRsvdMask) != '0) begin
            phase_nxt  = PH_STOPPED;
            status_nxt = ST_BAD_METHOD;
          end else begin
            flags_nxt = item.in_byte[FlagsW:1];
            skip_nxt  = FixedSkip;
            phase_nxt = PH_SKIP6;
          end
        end
        PH_SKIP6: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            sect = enter_section(PH_XLEN_LO, flags_r);
          end
        end
        PH_XLEN_LO: begin
          xlen_lo_nxt = item.in_byte;
          phase_nxt   = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_nxt = xlen_full;
          if (xlen_full == '0) begin
            sect = enter_section(PH_NAME, flags_r);
          end else begin
            phase_nxt = PH_XDATA;
          end
        end
        PH_XDATA: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            sect = enter_section(PH_NAME, flags_r);
          end
        end
        PH_NAME: begin
          if (item.in_byte == '0) begin
            sect = enter_section(PH_COMMENT, flags_r);
          end
        end
        PH_COMMENT: begin
          if (item.in_byte == '0) begin
            sect = enter_section(PH_HCRC, flags_r);
          end
        end
        PH_HCRC: begin
          crc_cnt_nxt = crc_inc;
          if (crc_inc >= CrcCntW'(2)) begin
            sect = enter_section(PH_PAYLOAD, flags_r);
          end
        end
        PH_PAYLOAD: begin
          pay_valid = 1'b1;
        end
        default: begin
          phase_nxt  = PH_STOPPED;
          status_nxt = ST_TRUNCATED;
        end
      endcase

      // apply a section hop chosen above
      if (sect.set_ok || sect.phase != PH_PAYLOAD) begin
        phase_nxt = sect.phase;
      end
      if (sect.set_ok) begin
        status_nxt = ST_OK;
      end
      if (sect.clr_crc) begin
        crc_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC1;
      skip_r    <= '0;
      xlen_lo_r <= '0;
      flags_r   <= '0;
      status_r  <= ST_HEADER;
      crc_cnt_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      xlen_lo_r <= xlen_lo_nxt;
      flags_r   <= flags_nxt;
      status_r  <= status_nxt;
      crc_cnt_r <= crc_cnt_nxt;
    end
  end

  assign result.payload_byte  = pay_valid ? item.in_byte : '0;
  assign result.payload_valid = pay_valid;
  assign result.status        = status_nxt;

endmodule

/* hdl/ghs_out_reg.sv */
// result word register feeding the output stream
module ghs_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ghs_pkg::result_t result,
  output logic             can_load,
  output logic             out_tvalid,
  input  logic             out_tready,
  output ghs_pkg::result_t held
);
  import ghs_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign held       = res_r;

endmodule

/* hdl/gzip_header_stripper.sv */
// top level of the gzip member header stripper
//
//  channel | dir | tdata                 | tuser
//  --------+-----+-----------------------+----------------------------------
//  in_     | in  | [7:0] in_byte         | [0] end_of_input
//  out_    | out | [7:0] payload_byte    | [0] payload_valid, [3:1] status
//
// one word in, one word out; a word passes from in_ to out_ through
// the input register, then parse logic into the output register
// sustained rate one word per clock while out_tready stays high; the parse step is combinational
// rst_n (synchronous, active low) returns the parser to the first magic byte
// a stall on out_tready holds the result register; the input register takes
// one more word only if it is empty, then in_tready stays low until the result word drains
module gzip_header_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] end_of_input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic [3:0] out_tuser   // [0] payload_valid, [3:1] status
);
  import ghs_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    can_load;
  logic    advance;     // held word moves through the parser this cycle
  result_t parse_res;
  result_t out_res;

  assign in_item.in_byte      = in_tdata;
  assign in_item.end_of_input = in_tuser[0];

  // a word advances when it is held and the result register has room
  assign advance = held_valid && can_load;

  ghs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // header state only moves on an advancing word
  ghs_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (held_item),
    .result (parse_res)
  );

  ghs_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (parse_res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .held       (out_res)
  );

  // pack the result word onto the stream
  assign out_tdata = out_res.payload_byte;
  assign out_tuser = {out_res.status, out_res.payload_valid};

endmodule
